### hdl/ppsf_pkg.sv
// shared command codes and controller command type for the ping-pong sample fifo
package ppsf_pkg;

    typedef enum logic [2:0] {
        CMD_PUSH    = 3'd0,
        CMD_QUERY   = 3'd1,
        CMD_READ    = 3'd2,
        CMD_DISCARD = 3'd3,
        CMD_CLEAR   = 3'd4
    } cmd_t;

    localparam int CMD_W     = 3;
    localparam int SAMPLE_W  = 32;
    localparam int OFFSET_W  = 8;
    localparam int DISCARD_W = 16;

    typedef struct packed {
        logic take;     // input transaction accepted this cycle
        logic load_rd;  // ram read data is present, capture it
    } ctrl_t;

endpackage

### hdl/ppsf_req_if.sv
// request and response channel interfaces of the ping-pong sample fifo
interface ppsf_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         cmd;
    logic signed [31:0] sample;
    logic [7:0]         offset;
    logic [15:0]        discard_count;

    modport source (output valid, output cmd, output sample, output offset,
                    output discard_count, input ready);
    modport sink (input valid, input cmd, input sample, input offset,
                  input discard_count, output ready);
endinterface

interface ppsf_rsp_if #(parameter int CNT_W = 9);
    logic               valid;
    logic               ready;
    logic               ready_res;
    logic signed [31:0] read_data;
    logic               read_valid;
    logic [CNT_W-1:0]   standby_count;
    logic               dropped;

    modport source (output valid, output ready_res, output read_data, output read_valid,
                    output standby_count, output dropped, input ready);
    modport sink (input valid, input ready_res, input read_data, input read_valid,
                  input standby_count, input dropped, output ready);
endinterface

### hdl/ping_pong_sample_fifo.sv
// Ping-pong sample fifo, top level.
// Two circular sample banks of QUEUE_DEPTH words: the active bank takes pushed
// samples, the standby bank is read, trimmed or cleared by the reader.
// Channels: req carries one command transaction (cmd, sample, offset,
// discard_count); rsp returns exactly one result transaction per request
// (ready_res, read_data, read_valid, standby_count, dropped).
// A ready query swaps the banks only when the standby bank is empty and then
// empties the new active bank. A push into a full active bank is dropped.
// After a request is accepted the controller passes through a load state,
// where the registered read port of the sample ram delivers the read data,
// and then raises rsp.valid in its send state.
// The block holds one request at a time: req.ready stays low from accept
// until the result transaction completes, so a stalled receiver holds off
// the next request while the result waits in its output register.
// Reset clears both banks to empty with bank zero active; req.ready is registered
// and rises from the idle state once reset is released. Sample storage is not cleared.
module ping_pong_sample_fifo #(
    parameter int QUEUE_DEPTH = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    ppsf_req_if.sink          req,
    ppsf_rsp_if.source        rsp
);
    import ppsf_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    ctrl_t            ctl;
    logic [CNT_W-1:0] standby_count;

    ppsf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .ctl       (ctl)
    );

    ppsf_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .CNT_W       (CNT_W)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .cmd           (req.cmd),
        .sample        (req.sample),
        .offset        (req.offset),
        .discard_count (req.discard_count),
        .ready_res     (rsp.ready_res),
        .read_data     (rsp.read_data),
        .read_valid    (rsp.read_valid),
        .standby_count (standby_count),
        .dropped       (rsp.dropped)
    );

    assign rsp.standby_count = standby_count;
endmodule

### hdl/ppsf_ram.sv
// generic single write port ram with registered read
module ppsf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

### hdl/ppsf_ctrl.sv
// controller state machine: accept, wait for ram read, present result
module ppsf_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    output ppsf_pkg::ctrl_t ctl
);
    import ppsf_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SEND
    } state_t;

    state_t state_reg;
    logic   in_ready_reg;
    logic   out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            in_ready_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid && in_ready_reg)
                    begin
                        in_ready_reg <= 1'b0;
                        state_reg    <= ST_LOAD;
                    end
                    else
                    begin
                        in_ready_reg <= 1'b1;
                    end
                end
                ST_LOAD:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= ST_SEND;
                end
                ST_SEND:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        in_ready_reg  <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_ready    = in_ready_reg;
    assign out_valid   = out_valid_reg;
    assign ctl.take    = in_valid && in_ready_reg;
    assign ctl.load_rd = (state_reg == ST_LOAD);
endmodule

### hdl/ppsf_dp.sv
// datapath: bank pointers and counts, two sample rams, result registers
module ppsf_dp #(
    parameter int QUEUE_DEPTH = 256,
    parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  ppsf_pkg::ctrl_t                      ctl,
    input  logic [ppsf_pkg::CMD_W-1:0]           cmd,
    input  logic signed [ppsf_pkg::SAMPLE_W-1:0] sample,
    input  logic [ppsf_pkg::OFFSET_W-1:0]        offset,
    input  logic [ppsf_pkg::DISCARD_W-1:0]       discard_count,
    output logic                                 ready_res,
    output logic signed [ppsf_pkg::SAMPLE_W-1:0] read_data,
    output logic                                 read_valid,
    output logic [CNT_W-1:0]                     standby_count,
    output logic                                 dropped
);
    import ppsf_pkg::*;

    localparam int IW   = $clog2(QUEUE_DEPTH);
    localparam int SW   = ((IW > OFFSET_W) ? IW : OFFSET_W) + 1;
    localparam int CMPW = (CNT_W > OFFSET_W) ? CNT_W : OFFSET_W;

    logic [IW-1:0]    head_reg  [2];
    logic [IW-1:0]    tail_reg  [2];
    logic [CNT_W-1:0] count_reg [2];
    logic             act_reg;

    logic [IW-1:0]    head_next  [2];
    logic [IW-1:0]    tail_next  [2];
    logic [CNT_W-1:0] count_next [2];
    logic             act_next;

    logic             act;
    logic             stb;
    logic             full;
    logic             rd_hit;
    logic [SW-1:0]    rd_sum;
    logic [IW-1:0]    rd_addr;
    logic [CNT_W-1:0] ndisc;
    logic [SW-1:0]    disc_sum;
    logic             ram_we [2];
    logic [SAMPLE_W-1:0] ram_q [2];

    logic             ready_next;
    logic             hit_next;
    logic             drop_next;

    logic             ready_res_reg;
    logic             read_valid_reg;
    logic             dropped_reg;
    logic [CNT_W-1:0] count_res_reg;
    logic             rd_bank_reg;
    logic [SAMPLE_W-1:0] read_data_reg;

    assign act  = act_reg;
    assign stb  = ~act_reg;
    assign full = (count_reg[act] == CNT_W'(QUEUE_DEPTH));

    // standby read address, head plus offset wrapped once
    always_comb
    begin
        rd_hit = (CMPW'(offset) < CMPW'(count_reg[stb]));
        rd_sum = SW'(head_reg[stb]) + SW'(offset);
        if (rd_sum >= SW'(QUEUE_DEPTH))
        begin
            rd_sum = rd_sum - SW'(QUEUE_DEPTH);
        end
        rd_addr = rd_sum[IW-1:0];
    end

    // discard clipped to the standby count
    always_comb
    begin
        if (discard_count > DISCARD_W'(count_reg[stb]))
        begin
            ndisc = count_reg[stb];
        end
        else
        begin
            ndisc = CNT_W'(discard_count);
        end
        disc_sum = SW'(head_reg[stb]) + SW'(ndisc);
        if (disc_sum >= SW'(QUEUE_DEPTH))
        begin
            disc_sum = disc_sum - SW'(QUEUE_DEPTH);
        end
    end

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        act_next   = act_reg;
        ram_we[0]  = 1'b0;
        ram_we[1]  = 1'b0;
        ready_next = 1'b0;
        hit_next   = 1'b0;
        drop_next  = 1'b0;
        if (ctl.take)
        begin
            unique case (cmd)
                CMD_PUSH:
                begin
                    if (full)
                    begin
                        drop_next = 1'b1;
                    end
                    else
                    begin
                        ram_we[act] = 1'b1;
                        if (tail_reg[act] == IW'(QUEUE_DEPTH - 1))
                        begin
                            tail_next[act] = '0;
                        end
                        else
                        begin
                            tail_next[act] = tail_reg[act] + 1'b1;
                        end
                        count_next[act] = count_reg[act] + 1'b1;
                    end
                end
                CMD_QUERY:
                begin
                    if (count_reg[stb] == '0)
                    begin
                        // swap: old standby becomes active and starts empty
                        act_next        = stb;
                        head_next[stb]  = '0;
                        tail_next[stb]  = '0;
                        count_next[stb] = '0;
                        ready_next      = (count_reg[act] != '0);
                    end
                    else
                    begin
                        ready_next = 1'b1;
                    end
                end
                CMD_READ:
                begin
                    hit_next = rd_hit;
                end
                CMD_DISCARD:
                begin
                    head_next[stb]  = disc_sum[IW-1:0];
                    count_next[stb] = count_reg[stb] - ndisc;
                end
                CMD_CLEAR:
                begin
                    head_next[stb]  = '0;
                    tail_next[stb]  = '0;
                    count_next[stb] = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < 2; b++)
            begin
                head_reg[b]  <= '0;
                tail_reg[b]  <= '0;
                count_reg[b] <= '0;
            end
            act_reg <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            act_reg   <= act_next;
        end
    end

    // result registers, loaded at accept; read data loaded in the following load state
    always_ff @(posedge clk)
    begin
        if (ctl.take)
        begin
            ready_res_reg  <= ready_next;
            read_valid_reg <= hit_next;
            dropped_reg    <= drop_next;
            count_res_reg  <= count_next[~act_next];
            rd_bank_reg    <= stb;
        end
        if (ctl.load_rd)
        begin
            read_data_reg <= read_valid_reg ? ram_q[rd_bank_reg] : '0;
        end
    end

    for (genvar g = 0; g < 2; g++)
    begin : g_bank
        ppsf_ram #(
            .WIDTH (SAMPLE_W),
            .DEPTH (QUEUE_DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (ram_we[g]),
            .waddr (tail_reg[g]),
            .wdata (sample),
            .raddr (rd_addr),
            .rdata (ram_q[g])
        );
    end

    assign ready_res     = ready_res_reg;
    assign read_data     = read_data_reg;
    assign read_valid    = read_valid_reg;
    assign standby_count = count_res_reg;
    assign dropped       = dropped_reg;
endmodule

### bench/ppsf_checker.sv
`timescale 1ns / 100ps
// scoreboard for the ping-pong sample fifo: predicts every result and checks it
module ppsf_checker #(
    parameter int QUEUE_DEPTH = 256
) (
    input  logic clk,
    input  logic rst_n,
    ppsf_req_if  req_mon,
    ppsf_rsp_if  rsp_mon,
    output int   fail_count,
    output int   outstanding
);
    import ppsf_pkg::*;

    localparam int PRINT_CAP = 60;

    typedef struct packed {
        logic               ready_res;
        logic signed [31:0] read_data;
        logic               read_valid;
        logic [8:0]         standby_count;
        logic               dropped;
    } fifo_result_t;

    logic [31:0]  bank_mem [2][QUEUE_DEPTH];
    int unsigned  bank_head [2];
    int unsigned  bank_tail [2];
    int unsigned  bank_fill [2];
    logic         active_bank;
    fifo_result_t pending_results [$];
    int           mismatches = 0;
    int           results_seen = 0;

    assign fail_count  = mismatches;
    assign outstanding = pending_results.size();

    function automatic void reset_bank(logic b);
        bank_head[b] = 0;
        bank_tail[b] = 0;
        bank_fill[b] = 0;
    endfunction

    // applies one accepted transaction to the bank model and returns its result
    function automatic fifo_result_t predict_result(logic [2:0] cmd, logic [31:0] sample,
                                                    logic [7:0] offset, logic [15:0] discard);
        fifo_result_t r;
        logic         act;
        logic         stb;
        int unsigned  n;
        r   = '0;
        act = active_bank;
        stb = ~active_bank;
        case (cmd)
            CMD_PUSH:
            begin
                if (bank_fill[act] >= QUEUE_DEPTH)
                begin
                    r.dropped = 1'b1;
                end
                else
                begin
                    bank_mem[act][bank_tail[act]] = sample;
                    bank_tail[act] = (bank_tail[act] + 1) % QUEUE_DEPTH;
                    bank_fill[act] = bank_fill[act] + 1;
                end
            end
            CMD_QUERY:
            begin
                // swap only once the reader has drained the standby bank
                if (bank_fill[stb] == 0)
                begin
                    active_bank = stb;
                    act = stb;
                    stb = ~stb;
                    reset_bank(act);
                end
                r.ready_res = (bank_fill[stb] != 0);
            end
            CMD_READ:
            begin
                if (offset < bank_fill[stb])
                begin
                    r.read_valid = 1'b1;
                    r.read_data  = bank_mem[stb][(bank_head[stb] + offset) % QUEUE_DEPTH];
                end
            end
            CMD_DISCARD:
            begin
                n = (discard > bank_fill[stb]) ? bank_fill[stb] : discard;
                bank_head[stb] = (bank_head[stb] + n) % QUEUE_DEPTH;
                bank_fill[stb] = bank_fill[stb] - n;
            end
            CMD_CLEAR:
            begin
                reset_bank(stb);
            end
            default:
            begin
            end
        endcase
        r.standby_count = 9'(bank_fill[stb]);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (mismatches < PRINT_CAP)
        begin
            $display("%0t: result %0d %s: got %0h, expected %0h",
                     $realtime, results_seen, what, got, want);
        end
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        fifo_result_t want;
        if (!rst_n)
        begin
            reset_bank(1'b0);
            reset_bank(1'b1);
            active_bank = 1'b0;
            pending_results.delete();
        end
        else
        begin
            if (rsp_mon.valid && rsp_mon.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    report_mismatch("with no transaction pending", 0, 0);
                end
                else
                begin
                    want = pending_results[0];
                    pending_results.delete(0);
                    if (rsp_mon.ready_res !== want.ready_res)
                        report_mismatch("ready_res", 32'(rsp_mon.ready_res), 32'(want.ready_res));
                    if (rsp_mon.read_data !== want.read_data)
                        report_mismatch("read_data", rsp_mon.read_data, want.read_data);
                    if (rsp_mon.read_valid !== want.read_valid)
                        report_mismatch("read_valid", 32'(rsp_mon.read_valid),
                                        32'(want.read_valid));
                    if (rsp_mon.standby_count !== want.standby_count)
                        report_mismatch("standby_count", 32'(rsp_mon.standby_count),
                                        32'(want.standby_count));
                    if (rsp_mon.dropped !== want.dropped)
                        report_mismatch("dropped", 32'(rsp_mon.dropped), 32'(want.dropped));
                end
                results_seen++;
            end
            if (req_mon.valid && req_mon.ready)
            begin
                pending_results.insert(pending_results.size(),
                                       predict_result(req_mon.cmd, req_mon.sample,
                                                      req_mon.offset, req_mon.discard_count));
            end
        end
    end

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps
// top of the ping-pong sample fifo bench: clock, reset, stimulus and verdict
module tb_top;
    import ppsf_pkg::*;

    localparam int QUEUE_DEPTH  = 256;
    localparam int CMD_CODES    = 1 << CMD_W;
    localparam int TOTAL_ITEMS  = 950;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 200000;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    int   items_sent  = 0;
    int   hold_req    = 0;
    int   hold_served = 0;
    int   hold_left   = 0;
    int   cycle_cnt   = 0;
    int   fail_count;
    int   outstanding;

    ppsf_req_if req_ch();
    ppsf_rsp_if rsp_ch();

    ping_pong_sample_fifo #(.QUEUE_DEPTH(QUEUE_DEPTH)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    ppsf_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) scoreboard (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_mon     (req_ch),
        .rsp_mon     (rsp_ch),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side: random stalls plus a long hold-off on request
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req != hold_served)
            begin
                hold_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    task automatic send_item(logic [2:0] cmd, logic [31:0] sample, logic [7:0] offset,
                             logic [15:0] discard);
        @(negedge clk);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.cmd           <= cmd;
        req_ch.sample        <= sample;
        req_ch.offset        <= offset;
        req_ch.discard_count <= discard;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // one ping-pong round: fill the active bank, swap, then work the standby bank
    task automatic run_frame();
        int n;
        int ops;
        int pick;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        for (int i = 0; i < n; i++)
            send_item(CMD_PUSH, $urandom, 8'($urandom), 16'($urandom));
        send_item(CMD_QUERY, $urandom, 8'($urandom), 16'($urandom));
        ops = $urandom_range(1, 6);
        for (int i = 0; i < ops; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                send_item(CMD_READ, $urandom, 8'($urandom_range(0, n + 2)), 16'($urandom));
            else if (pick < 50)
                send_item(CMD_READ, $urandom, 8'($urandom), 16'($urandom));
            else if (pick < 65)
                send_item(CMD_DISCARD, $urandom, 8'($urandom), 16'($urandom_range(0, 3)));
            else if (pick < 70)
                send_item(CMD_DISCARD, $urandom, 8'($urandom), 16'($urandom));
            else if (pick < 80)
                send_item(CMD_PUSH, $urandom, 8'($urandom), 16'($urandom));
            else if (pick < 88)
                send_item(CMD_QUERY, $urandom, 8'($urandom), 16'($urandom));
            else
                send_item(3'($urandom_range(0, CMD_CODES - 1)), $urandom, 8'($urandom),
                          16'($urandom));
        end
        pick = $urandom_range(0, 3);
        if (pick == 0)
            send_item(CMD_CLEAR, $urandom, 8'($urandom), 16'($urandom));
        else if (pick == 1)
            send_item(CMD_DISCARD, $urandom, 8'($urandom), '1);
    endtask

    // pushes past capacity into an empty active bank, then reads it back as standby
    task automatic fill_bank_full();
        send_item(CMD_CLEAR, 0, 0, 0);
        send_item(CMD_QUERY, 0, 0, 0);
        send_item(CMD_CLEAR, 0, 0, 0);
        for (int i = 0; i < QUEUE_DEPTH + 4; i++)
            send_item(CMD_PUSH, $urandom, 8'($urandom), 16'($urandom));
        send_item(CMD_QUERY, 0, 0, 0);
        send_item(CMD_READ, 0, 8'(QUEUE_DEPTH - 1), 0);
        send_item(CMD_READ, 0, 0, 0);
        send_item(CMD_DISCARD, 0, 0, 16'd1);
        send_item(CMD_READ, 0, 8'(QUEUE_DEPTH - 1), 0);
        send_item(CMD_READ, 0, 8'(QUEUE_DEPTH - 2), 0);
        send_item(CMD_DISCARD, 0, 0, '1);
        send_item(CMD_QUERY, 0, 0, 0);
    endtask

    initial
    begin
        req_ch.valid         = 1'b0;
        req_ch.cmd           = CMD_PUSH;
        req_ch.sample        = '0;
        req_ch.offset        = '0;
        req_ch.discard_count = '0;
        tx_idle_pct = 32;
        rx_idle_pct = 85;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // empty banks, unused codes, swap with nothing held
        send_item(CMD_READ, 0, 8'd0, 0);
        send_item(CMD_DISCARD, 0, 0, '1);
        send_item(CMD_CLEAR, 0, 0, 0);
        for (int c = CMD_CLEAR + 1; c < CMD_CODES; c++)
            send_item(3'(c), $urandom, 8'($urandom), 16'($urandom));
        send_item(CMD_QUERY, 0, 0, 0);
        // sample extremes, swap into standby, reads in and out of range
        send_item(CMD_PUSH, 32'h7fff_ffff, 0, 0);
        send_item(CMD_PUSH, 32'h8000_0000, 0, 0);
        send_item(CMD_PUSH, 32'hffff_ffff, 0, 0);
        send_item(CMD_PUSH, 32'h0000_0000, 0, 0);
        send_item(CMD_QUERY, 0, 0, 0);
        send_item(CMD_PUSH, 32'h0000_0001, 0, 0);
        send_item(CMD_QUERY, 0, 0, 0);
        send_item(CMD_READ, 0, 8'd0, 0);
        send_item(CMD_READ, 0, 8'd3, 0);
        send_item(CMD_READ, 0, 8'd4, 0);
        send_item(CMD_READ, 0, '1, 0);
        send_item(CMD_DISCARD, 0, 0, 16'd1);
        send_item(CMD_READ, 0, 8'd0, 0);
        send_item(CMD_DISCARD, 0, 0, 16'd0);
        send_item(CMD_DISCARD, 0, 0, '1);
        send_item(CMD_QUERY, 0, 0, 0);
        send_item(CMD_CLEAR, 0, 0, 0);
        send_item(CMD_QUERY, 0, 0, 0);

        while (items_sent < 330)
            run_frame();

        tx_idle_pct = 85;
        rx_idle_pct = 32;
        hold_req++;
        while (items_sent < 520)
            run_frame();

        wait_drained();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        fill_bank_full();
        while (items_sent < TOTAL_ITEMS)
            run_frame();

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### files.f
hdl/ppsf_pkg.sv
hdl/ppsf_req_if.sv
hdl/ppsf_ram.sv
hdl/ppsf_ctrl.sv
hdl/ppsf_dp.sv
hdl/ping_pong_sample_fifo.sv
bench/ppsf_checker.sv
bench/tb_top.sv
